FILE: src/sm4_block_cipher_unit_macros.svh
// assertion helpers
`ifndef SM4_BLOCK_CIPHER_UNIT_MACROS_SVH
`define SM4_BLOCK_CIPHER_UNIT_MACROS_SVH

`define SM4_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("lbl");

`define SM4_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error("lbl");

`endif

FILE: src/sm4_pkg.sv
package sm4_pkg;

	localparam int WordW = 32;
	localparam int KeyIdxW = 5;

	typedef enum logic [1:0] {
		MODE_KEY = 2'd0,
		MODE_ENC = 2'd1,
		MODE_DEC = 2'd2,
		MODE_NOP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	// request to a round cell
	typedef struct packed {
		logic             load;
		logic             step;
	} cell_ctl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] tab [256];
		tab = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
		return tab[a];
	endfunction

	function automatic logic [WordW-1:0] t_xform(input logic [WordW-1:0] a);
		logic [WordW-1:0] b;
		b = {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
			^ {b[7:0], b[31:8]};
	endfunction

endpackage

FILE: src/sm4_block_cipher_unit.sv
// SM4 block cipher with an externally loaded key schedule. Mode 0 writes one round-key word
// (no result); mode 1 encrypts, mode 2 decrypts a 128-bit block, mode 3 is dropped.
// The first key is read from the key RAM in the acceptance cycle, then one round runs per
// cycle through a chain of four word cells fed by a single T-transform; the result is
// offered once all ROUNDS rounds are done. The next transaction is accepted the cycle after
// the result has been taken, so a block is not accepted while another is still in flight.
`include "sm4_block_cipher_unit_macros.svh"

module sm4_block_cipher_unit #(
	parameter int ROUNDS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// mode[1:0], key_index[6:2], key_word[38:7], block_high[102:39], block_low[166:103]
	input  logic [167:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_high[63:0], result_low[127:64]
	output logic [127:0] m_tdata
);
	import sm4_pkg::*;

	localparam int RndW = $clog2(ROUNDS + 1);

	state_t           state_q;
	logic             dec_q;
	logic [RndW-1:0]  rnd_q;
	logic [1:0]       mode;
	logic [KeyIdxW-1:0] raddr;
	logic [WordW-1:0] rk;
	logic [WordW-1:0] w [4];
	logic [WordW-1:0] ld [4];
	logic [WordW-1:0] nx [4];
	logic [WordW-1:0] new_word;
	logic             acc;
	cell_ctl_t        ctl;

	assign mode = s_tdata[1:0];
	assign acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// key fetch is one round ahead of the cells
	logic [RndW-1:0] fetch_r;
	always_comb begin
		fetch_r = acc ? '0 : rnd_q + RndW'(1);
		if (acc ? (mode == MODE_DEC) : dec_q) begin
			raddr = KeyIdxW'(ROUNDS - 1) - fetch_r[KeyIdxW-1:0];
		end else begin
			raddr = fetch_r[KeyIdxW-1:0];
		end
	end

	sm4_ram #(.Width(WordW), .Depth(ROUNDS)) u_keys (
		.clk(clk),
		.we(acc && mode == MODE_KEY),
		.waddr(s_tdata[6:2]),
		.wdata(s_tdata[38:7]),
		.raddr(raddr),
		.rdata(rk)
	);

	assign ld[0] = s_tdata[102:71];
	assign ld[1] = s_tdata[70:39];
	assign ld[2] = s_tdata[166:135];
	assign ld[3] = s_tdata[134:103];
	assign new_word = w[0] ^ t_xform(w[1] ^ w[2] ^ w[3] ^ rk);
	assign nx[0] = w[1];
	assign nx[1] = w[2];
	assign nx[2] = w[3];
	assign nx[3] = new_word;

	assign ctl.load = acc && (mode == MODE_ENC || mode == MODE_DEC);
	assign ctl.step = (state_q == ST_RUN);

	for (genvar i = 0; i < 4; i++) begin : g_cell
		sm4_cell u_cell (
			.clk(clk), .ctl(ctl), .load_word(ld[i]), .next_word(nx[i]), .word(w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			dec_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.load) begin
						state_q <= ST_RUN;
						rnd_q   <= '0;
						dec_q   <= (mode == MODE_DEC);
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + RndW'(1);
					if (rnd_q == RndW'(ROUNDS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {w[1], w[0], w[3], w[2]};

	`SM4_ASSERT(a_run_to_out, (state_q == ST_RUN && rnd_q == RndW'(ROUNDS - 1)) |=> m_tvalid)
	`SM4_ASSERT_NEVER(a_busy_ready, s_tready && m_tvalid)
	`SM4_ASSERT(a_load_runs, ctl.load |=> (state_q == ST_RUN && rnd_q == '0))
endmodule

FILE: src/sm4_ram.sv
module sm4_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/sm4_cell.sv
// one word of the state shift chain; the tail cell takes the new round word
module sm4_cell (
	input  logic                      clk,
	input  sm4_pkg::cell_ctl_t        ctl,
	input  logic [sm4_pkg::WordW-1:0] load_word,
	input  logic [sm4_pkg::WordW-1:0] next_word,
	output logic [sm4_pkg::WordW-1:0] word
);
	import sm4_pkg::*;

	logic [WordW-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= load_word;
		end else if (ctl.step) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;
endmodule
